// File: hdl/wsdf_pkg.sv
// Shared types, header position codes and tdata packing for the WebSocket deframer.
// No dependencies.
package wsdf_pkg;

    // Header byte position counter.
    typedef logic [3:0] t_hdr_pos;

    localparam t_hdr_pos HP_FIRST = 4'd0;   // FIN, RSV, opcode
    localparam t_hdr_pos HP_LEN   = 4'd1;   // MASK flag and 7-bit length
    localparam t_hdr_pos HP_EXT0  = 4'd2;   // extended length bytes, MSB first
    localparam t_hdr_pos HP_EXT1  = 4'd3;
    localparam t_hdr_pos HP_EXT2  = 4'd4;
    localparam t_hdr_pos HP_EXT3  = 4'd5;
    localparam t_hdr_pos HP_EXT4  = 4'd6;
    localparam t_hdr_pos HP_EXT5  = 4'd7;
    localparam t_hdr_pos HP_EXT6  = 4'd8;
    localparam t_hdr_pos HP_EXT7  = 4'd9;
    localparam t_hdr_pos HP_KEY0  = 4'd10;  // masking key bytes, MSB first
    localparam t_hdr_pos HP_KEY1  = 4'd11;
    localparam t_hdr_pos HP_KEY2  = 4'd12;
    localparam t_hdr_pos HP_KEY3  = 4'd13;

    // Result word kinds carried on tuser.
    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    // Short-length escape codes in the 7-bit length field.
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    localparam int unsigned TDATA_W = 120;

    // Fields of one result word other than kind and last.
    typedef struct packed {
        logic        fin;
        logic [2:0]  rsv;
        logic [3:0]  opcode;
        logic        mask;
        logic [63:0] length;
        logic [31:0] key;
        logic [7:0]  pbyte;
    } t_result;

    // Pack result fields into tdata, first field in the lowest bits.
    function automatic logic [TDATA_W-1:0] pack_tdata(input t_result r);
        logic [TDATA_W-1:0] d;
        d           = '0;
        d[0]        = r.fin;
        d[3:1]      = r.rsv;
        d[7:4]      = r.opcode;
        d[8]        = r.mask;
        d[72:9]     = r.length;
        d[104:73]   = r.key;
        d[112:105]  = r.pbyte;
        return d;
    endfunction

endpackage

// File: hdl/websocket_frame_deframer.sv
// WebSocket frame deframer: parses frame headers and unmasks payload bytes.
// Depends on wsdf_pkg.
//
//  Port group      Dir  Payload (low bit up)                           Accepted when
//  s_axis_*        in   tdata[7:0] rx_byte                             tvalid & tready
//  m_axis_*        out  tuser item_kind, tlast last_byte, tdata fields tvalid & tready
//
// Each accepted byte is decoded against the header/payload state, and its result,
// if any, lands in the output register on the same clock edge that accepts the byte.
// The 64-bit remaining-count decrement and compare sets the cycle time.
// i_rst_n is synchronous and active low; it clears parse state and the output valid.
// The input is ready whenever the output register is empty or being drained, so
// a byte is taken every cycle unless the downstream side stalls.
module websocket_frame_deframer
    import wsdf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // [7:0] rx_byte
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // [0] fin_flag, [3:1] rsv_bits, [7:4] frame_opcode, [8] mask_present,
    // [72:9] payload_length, [104:73] masking_key, [112:105] payload_byte, zero above
    output logic [TDATA_W-1:0] m_axis_tdata,
    output logic               m_axis_tuser,   // [0] item_kind
    output logic               m_axis_tlast    // last_byte
);

    // Parse state.
    t_hdr_pos    r_hdr_pos,  n_hdr_pos;
    logic        r_long,     n_long;
    logic        r_in_pay,   n_in_pay;
    logic        r_fin,      n_fin;
    logic [2:0]  r_rsv,      n_rsv;
    logic [3:0]  r_opcode,   n_opcode;
    logic        r_mask,     n_mask;
    logic [63:0] r_len,      n_len;
    logic [31:0] r_key,      n_key;
    logic [63:0] r_rem,      n_rem;
    logic [1:0]  r_kidx,     n_kidx;

    // Output register.
    logic               r_out_valid, n_out_valid;
    logic [TDATA_W-1:0] r_out_data,  n_out_data;
    logic               r_out_kind,  n_out_kind;
    logic               r_out_last,  n_out_last;

    logic        in_acc;
    logic        emit;
    logic        hdr_done;
    logic        pay_last;
    logic [7:0]  key_byte;
    logic [7:0]  pbyte;
    t_result     res;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // Key byte for the current payload index, most significant byte first.
    always_comb begin
        unique case (r_kidx)
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
    end

    assign pay_last = (r_rem == 64'd1);

    // Header parsing and payload unmasking for one accepted byte.
    always_comb begin
        n_hdr_pos = r_hdr_pos;
        n_long    = r_long;
        n_in_pay  = r_in_pay;
        n_fin     = r_fin;
        n_rsv     = r_rsv;
        n_opcode  = r_opcode;
        n_mask    = r_mask;
        n_len     = r_len;
        n_key     = r_key;
        n_rem     = r_rem;
        n_kidx    = r_kidx;
        emit      = 1'b0;
        hdr_done  = 1'b0;
        pbyte     = 8'd0;
        if (in_acc) begin
            if (r_in_pay) begin
                pbyte  = s_axis_tdata ^ (r_mask ? key_byte : 8'd0);
                n_kidx = r_kidx + 2'd1;
                n_rem  = r_rem - 64'd1;
                emit   = 1'b1;
                if (pay_last) begin
                    n_in_pay  = 1'b0;
                    n_hdr_pos = HP_FIRST;
                end
            end else begin
                unique case (r_hdr_pos)
                    HP_LEN: begin
                        n_mask = s_axis_tdata[7];
                        n_len  = {57'd0, s_axis_tdata[6:0]};
                        if (s_axis_tdata[6:0] != LEN_EXT16 &&
                            s_axis_tdata[6:0] != LEN_EXT64) begin
                            if (!s_axis_tdata[7]) begin
                                hdr_done = 1'b1;
                            end else begin
                                n_hdr_pos = HP_KEY0;
                            end
                        end else begin
                            n_long    = (s_axis_tdata[6:0] == LEN_EXT64);
                            n_hdr_pos = HP_EXT0;
                        end
                    end
                    HP_EXT0: begin
                        n_len     = {56'd0, s_axis_tdata};
                        n_hdr_pos = HP_EXT1;
                    end
                    HP_EXT1: begin
                        n_len = {r_len[55:0], s_axis_tdata};
                        if (r_long) begin
                            n_hdr_pos = HP_EXT2;
                        end else if (!r_mask) begin
                            hdr_done = 1'b1;
                        end else begin
                            n_hdr_pos = HP_KEY0;
                        end
                    end
                    HP_EXT2, HP_EXT3, HP_EXT4, HP_EXT5, HP_EXT6: begin
                        n_len     = {r_len[55:0], s_axis_tdata};
                        n_hdr_pos = r_hdr_pos + 4'd1;
                    end
                    HP_EXT7: begin
                        n_len = {r_len[55:0], s_axis_tdata};
                        if (!r_mask) begin
                            hdr_done = 1'b1;
                        end else begin
                            n_hdr_pos = HP_KEY0;
                        end
                    end
                    HP_KEY0: begin
                        n_key     = {24'd0, s_axis_tdata};
                        n_hdr_pos = HP_KEY1;
                    end
                    HP_KEY1, HP_KEY2: begin
                        n_key     = {r_key[23:0], s_axis_tdata};
                        n_hdr_pos = r_hdr_pos + 4'd1;
                    end
                    HP_KEY3: begin
                        n_key    = {r_key[23:0], s_axis_tdata};
                        hdr_done = 1'b1;
                    end
                    default: begin
                        // First header byte; unused positions restart here too.
                        n_fin     = s_axis_tdata[7];
                        n_rsv     = s_axis_tdata[6:4];
                        n_opcode  = s_axis_tdata[3:0];
                        n_mask    = 1'b0;
                        n_len     = 64'd0;
                        n_key     = 32'd0;
                        n_long    = 1'b0;
                        n_hdr_pos = HP_LEN;
                    end
                endcase
                // Header complete: report it and arm the payload counter.
                if (hdr_done) begin
                    n_hdr_pos = HP_FIRST;
                    n_long    = 1'b0;
                    n_kidx    = 2'd0;
                    n_rem     = n_len;
                    n_in_pay  = (n_len != 64'd0);
                    emit      = 1'b1;
                end
            end
        end
    end

    // Result fields reflect the state after this byte.
    always_comb begin
        res.fin    = n_fin;
        res.rsv    = n_rsv;
        res.opcode = n_opcode;
        res.mask   = n_mask;
        res.length = n_len;
        res.key    = n_key;
        res.pbyte  = pbyte;
    end

    // Output register: load on a result, clear when taken.
    always_comb begin
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        n_out_kind  = r_out_kind;
        n_out_last  = r_out_last;
        if (emit) begin
            n_out_valid = 1'b1;
            n_out_data  = pack_tdata(res);
            n_out_kind  = r_in_pay ? KIND_PAYLOAD : KIND_HEADER;
            n_out_last  = r_in_pay && pay_last;
        end
    end

    // Control state with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_pos   <= HP_FIRST;
            r_long      <= 1'b0;
            r_in_pay    <= 1'b0;
            r_fin       <= 1'b0;
            r_rsv       <= 3'd0;
            r_opcode    <= 4'd0;
            r_mask      <= 1'b0;
            r_len       <= 64'd0;
            r_key       <= 32'd0;
            r_rem       <= 64'd0;
            r_kidx      <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_hdr_pos   <= n_hdr_pos;
            r_long      <= n_long;
            r_in_pay    <= n_in_pay;
            r_fin       <= n_fin;
            r_rsv       <= n_rsv;
            r_opcode    <= n_opcode;
            r_mask      <= n_mask;
            r_len       <= n_len;
            r_key       <= n_key;
            r_rem       <= n_rem;
            r_kidx      <= n_kidx;
            r_out_valid <= n_out_valid;
        end
    end

    // Output payload needs no reset.
    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_out_kind <= n_out_kind;
        r_out_last <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

    // The header counter sits at the start position throughout a payload.
    a_pay_hdr_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_pay |-> (r_hdr_pos == HP_FIRST))
        else $error("header position moved during payload");

    // A payload phase always has bytes left to pass.
    a_pay_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_pay |-> (r_rem != 64'd0))
        else $error("payload phase with zero bytes remaining");

    // The final payload byte ends the payload phase.
    a_last_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_in_pay && pay_last) |=> !r_in_pay)
        else $error("payload phase continued past last byte");

    // Unused header positions are never entered.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hdr_pos <= HP_KEY3)
        else $error("header position out of range");

endmodule
